// File: rtl/rvenc_pkg.sv
`default_nettype none

package rvenc_pkg;

    localparam int unsigned OP_W     = 6;
    localparam int unsigned REG_W    = 5;
    localparam int unsigned IMM_W    = 21;
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned STATUS_W = 2;

    // Major opcodes of the base integer set.
    localparam logic [6:0] OPC_OP     = 7'b0110011;
    localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
    localparam logic [6:0] OPC_JALR   = 7'b1100111;
    localparam logic [6:0] OPC_LOAD   = 7'b0000011;
    localparam logic [6:0] OPC_STORE  = 7'b0100011;
    localparam logic [6:0] OPC_BRANCH = 7'b1100011;
    localparam logic [6:0] OPC_JAL    = 7'b1101111;
    localparam logic [6:0] OPC_LUI    = 7'b0110111;
    localparam logic [6:0] F7_BASE    = 7'b0000000;
    localparam logic [6:0] F7_ALT     = 7'b0100000;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN = 2'd2;

    typedef enum logic [OP_W-1:0] {
        MN_ADD, MN_SUB, MN_AND, MN_OR, MN_XOR, MN_SLL, MN_SRL, MN_SRA,
        MN_ADDI, MN_ANDI, MN_ORI, MN_XORI, MN_SLLI, MN_SRLI, MN_SRAI,
        MN_JALR, MN_LD, MN_LW, MN_LH, MN_LB, MN_LWU, MN_LHU, MN_LBU,
        MN_SD, MN_SW, MN_SH, MN_SB,
        MN_BEQ, MN_BNE, MN_BLT, MN_BGE, MN_BLTU, MN_BGEU,
        MN_JAL, MN_LUI
    } t_mnem;

    typedef enum logic [2:0] {
        FMT_R, FMT_I, FMT_SH, FMT_S, FMT_B, FMT_J, FMT_U, FMT_BAD
    } t_fmt;

    typedef struct packed {
        t_fmt       fmt;
        logic [6:0] opcode;
        logic [2:0] f3;
        logic [6:0] f7;
    } t_op_desc;

    function automatic t_op_desc op_decode(input logic [OP_W-1:0] op);
        t_op_desc d;
        d = '{fmt: FMT_BAD, opcode: 7'd0, f3: 3'd0, f7: F7_BASE};
        case (op)
            MN_ADD:  d = '{FMT_R, OPC_OP, 3'd0, F7_BASE};
            MN_SUB:  d = '{FMT_R, OPC_OP, 3'd0, F7_ALT};
            MN_AND:  d = '{FMT_R, OPC_OP, 3'd7, F7_BASE};
            MN_OR:   d = '{FMT_R, OPC_OP, 3'd6, F7_BASE};
            MN_XOR:  d = '{FMT_R, OPC_OP, 3'd4, F7_BASE};
            MN_SLL:  d = '{FMT_R, OPC_OP, 3'd1, F7_BASE};
            MN_SRL:  d = '{FMT_R, OPC_OP, 3'd5, F7_BASE};
            MN_SRA:  d = '{FMT_R, OPC_OP, 3'd5, F7_ALT};
            MN_ADDI: d = '{FMT_I, OPC_OPIMM, 3'd0, F7_BASE};
            MN_ANDI: d = '{FMT_I, OPC_OPIMM, 3'd7, F7_BASE};
            MN_ORI:  d = '{FMT_I, OPC_OPIMM, 3'd6, F7_BASE};
            MN_XORI: d = '{FMT_I, OPC_OPIMM, 3'd4, F7_BASE};
            MN_SLLI: d = '{FMT_SH, OPC_OPIMM, 3'd1, F7_BASE};
            MN_SRLI: d = '{FMT_SH, OPC_OPIMM, 3'd5, F7_BASE};
            MN_SRAI: d = '{FMT_SH, OPC_OPIMM, 3'd5, F7_ALT};
            MN_JALR: d = '{FMT_I, OPC_JALR, 3'd0, F7_BASE};
            MN_LD:   d = '{FMT_I, OPC_LOAD, 3'd3, F7_BASE};
            MN_LW:   d = '{FMT_I, OPC_LOAD, 3'd2, F7_BASE};
            MN_LH:   d = '{FMT_I, OPC_LOAD, 3'd1, F7_BASE};
            MN_LB:   d = '{FMT_I, OPC_LOAD, 3'd0, F7_BASE};
            MN_LWU:  d = '{FMT_I, OPC_LOAD, 3'd6, F7_BASE};
            MN_LHU:  d = '{FMT_I, OPC_LOAD, 3'd5, F7_BASE};
            MN_LBU:  d = '{FMT_I, OPC_LOAD, 3'd4, F7_BASE};
            MN_SD:   d = '{FMT_S, OPC_STORE, 3'd3, F7_BASE};
            MN_SW:   d = '{FMT_S, OPC_STORE, 3'd2, F7_BASE};
            MN_SH:   d = '{FMT_S, OPC_STORE, 3'd1, F7_BASE};
            MN_SB:   d = '{FMT_S, OPC_STORE, 3'd0, F7_BASE};
            MN_BEQ:  d = '{FMT_B, OPC_BRANCH, 3'd0, F7_BASE};
            MN_BNE:  d = '{FMT_B, OPC_BRANCH, 3'd1, F7_BASE};
            MN_BLT:  d = '{FMT_B, OPC_BRANCH, 3'd4, F7_BASE};
            MN_BGE:  d = '{FMT_B, OPC_BRANCH, 3'd5, F7_BASE};
            MN_BLTU: d = '{FMT_B, OPC_BRANCH, 3'd6, F7_BASE};
            MN_BGEU: d = '{FMT_B, OPC_BRANCH, 3'd7, F7_BASE};
            MN_JAL:  d = '{FMT_J, OPC_JAL, 3'd0, F7_BASE};
            MN_LUI:  d = '{FMT_U, OPC_LUI, 3'd0, F7_BASE};
            default: d = '{FMT_BAD, 7'd0, 3'd0, F7_BASE};
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// File: rtl/rvenc_core.sv
`default_nettype none

module rvenc_core
    import rvenc_pkg::*;
(
    input  wire logic [OP_W-1:0]     i_op,
    input  wire logic [REG_W-1:0]    i_rd,
    input  wire logic [REG_W-1:0]    i_rs1,
    input  wire logic [REG_W-1:0]    i_rs2,
    input  wire logic [IMM_W-1:0]    i_imm,
    output logic      [WORD_W-1:0]   o_word,
    output logic      [STATUS_W-1:0] o_status
);

    t_op_desc          d;
    logic              fits12;
    logic              fits13;
    logic              fits_sh;
    logic              fits_u;
    logic [WORD_W-1:0] w;
    logic [STATUS_W-1:0] st;

    // A signed value fits n bits when every bit above n-1 copies the sign.
    assign fits12  = (i_imm[IMM_W-1:11] == '0) || (i_imm[IMM_W-1:11] == '1);
    assign fits13  = (i_imm[IMM_W-1:12] == '0) || (i_imm[IMM_W-1:12] == '1);
    assign fits_sh = (i_imm[IMM_W-1:6] == '0);
    assign fits_u  = ~i_imm[IMM_W-1];

    always_comb begin
        d  = op_decode(i_op);
        w  = '0;
        st = ST_OK;
        unique case (d.fmt)
            FMT_R: begin
                w = {d.f7, i_rs2, i_rs1, d.f3, i_rd, d.opcode};
            end
            FMT_I: begin
                if (!fits12) st = ST_RANGE;
                w = {i_imm[11:0], i_rs1, d.f3, i_rd, d.opcode};
            end
            FMT_SH: begin
                if (!fits_sh) st = ST_RANGE;
                w = {d.f7[6:1], i_imm[5:0], i_rs1, d.f3, i_rd, d.opcode};
            end
            FMT_S: begin
                if (!fits12) st = ST_RANGE;
                w = {i_imm[11:5], i_rs2, i_rs1, d.f3, i_imm[4:0], d.opcode};
            end
            FMT_B: begin
                if (!fits13) st = ST_RANGE;
                w = {i_imm[12], i_imm[10:5], i_rs2, i_rs1, d.f3,
                     i_imm[4:1], i_imm[11], d.opcode};
            end
            FMT_J: begin
                w = {i_imm[20], i_imm[10:1], i_imm[11], i_imm[19:12], i_rd, d.opcode};
            end
            FMT_U: begin
                if (!fits_u) st = ST_RANGE;
                w = {i_imm[19:0], i_rd, d.opcode};
            end
            FMT_BAD: begin
                st = ST_UNKNOWN;
            end
        endcase
        // Any error forces the word to zero.
        o_word   = (st == ST_OK) ? w : '0;
        o_status = st;
    end

endmodule

`default_nettype wire

// File: rtl/rv64i_instruction_encoder.sv
// Channel   Handshake         Ports
// -------   ---------------   ------------------------------------------
// command   start, busy       i_op, i_rd, i_rs1, i_rs2, i_imm
// result    o_valid strobe    o_word, o_status
//
// A word is taken at every rising edge where start is high and busy is low.
// Its result then passes through the input register, which feeds the encoder, and
// the result register, which catches its output, and is strobed on o_valid.
// One word can be accepted and one result given per cycle while busy is low.
// Reset is synchronous and active low; busy is high while reset is applied.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none

module rv64i_instruction_encoder
    import rvenc_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [OP_W-1:0]     i_op,
    input  wire logic [REG_W-1:0]    i_rd,
    input  wire logic [REG_W-1:0]    i_rs1,
    input  wire logic [REG_W-1:0]    i_rs2,
    input  wire logic [IMM_W-1:0]    i_imm,
    output logic                     o_valid,
    output logic      [WORD_W-1:0]   o_word,
    output logic      [STATUS_W-1:0] o_status
);

    // Control registers.
    logic                r_busy;
    logic                r_in_valid;
    logic                r_valid;

    // Input register holding the accepted instruction fields.
    logic [OP_W-1:0]     r_op;
    logic [REG_W-1:0]    r_rd;
    logic [REG_W-1:0]    r_rs1;
    logic [REG_W-1:0]    r_rs2;
    logic [IMM_W-1:0]    r_imm;

    // Result register.
    logic [WORD_W-1:0]   r_word;
    logic [STATUS_W-1:0] r_status;

    logic [WORD_W-1:0]   n_word;
    logic [STATUS_W-1:0] n_status;
    logic                n_in_valid;

    // The block never holds off a command once out of reset, since the
    // encoder finishes one word in every cycle.
    assign n_in_valid = start & ~r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_in_valid <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            r_busy     <= 1'b0;
            r_in_valid <= n_in_valid;
            r_valid    <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_in_valid) begin
            r_op  <= i_op;
            r_rd  <= i_rd;
            r_rs1 <= i_rs1;
            r_rs2 <= i_rs2;
            r_imm <= i_imm;
        end
    end

    rvenc_core u_core (
        .i_op     (r_op),
        .i_rd     (r_rd),
        .i_rs1    (r_rs1),
        .i_rs2    (r_rs2),
        .i_imm    (r_imm),
        .o_word   (n_word),
        .o_status (n_status)
    );

    always_ff @(posedge i_clk) begin
        if (r_in_valid) begin
            r_word   <= n_word;
            r_status <= n_status;
        end
    end

    assign busy     = r_busy;
    assign o_valid  = r_valid;
    assign o_word   = r_word;
    assign o_status = r_status;

endmodule

`default_nettype wire

// File: rtl/rvenc_checker.sv
`default_nettype none

module rvenc_checker
    import rvenc_pkg::*;
(
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                start,
    input wire logic                busy,
    input wire logic                o_valid,
    input wire logic [WORD_W-1:0]   o_word,
    input wire logic [STATUS_W-1:0] o_status
);

    // Every accepted command later yields its result on o_valid.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_valid)
        else $error("result missing two cycles after a command");

    // No result appears without a matching earlier command.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 2))
        else $error("result without a matching command");

    // An error status always comes with a zero word.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_OK)) |-> (o_word == '0))
        else $error("nonzero word with an error status");

    // Status is one of the three defined codes.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ST_OK || o_status == ST_RANGE || o_status == ST_UNKNOWN))
        else $error("undefined status code");

    // Every valid base-set encoding ends in the two low bits set.
    a_low_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_OK)) |-> (o_word[1:0] == 2'b11))
        else $error("encoded word lacks the 32-bit length marker");

endmodule

bind rv64i_instruction_encoder rvenc_checker u_rvenc_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_valid  (o_valid),
    .o_word   (o_word),
    .o_status (o_status)
);

`default_nettype wire
